>>> hdl/two_level_ready_queue_dispatch_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ready-queue dispatcher
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_READY_QUEUE_DISPATCH_TOP_ASSERT_SVH
`define TWO_LEVEL_READY_QUEUE_DISPATCH_TOP_ASSERT_SVH

// same-cycle implication
`define TLRQ_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tlrq assertion failed");

// next-cycle implication
`define TLRQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tlrq assertion failed");

`endif

>>> hdl/tlrq_pkg.sv
// ----------------------------------------------------------------------------
// tlrq_pkg
// Types and constants shared by the ready-queue dispatcher.
// ----------------------------------------------------------------------------
package tlrq_pkg;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_CODE   = 1'b1;

  localparam logic [ID_W-1:0] PROCESS_LIMIT_RST = 8'd64;
  localparam logic [ID_W-1:0] SIGNAL_CODE_RST   = 8'd255;
  localparam logic [ID_W-1:0] IDLE_ID           = 8'd0;

  typedef enum logic [1:0] {
    MODE_ENQ_LOW  = 2'd0,
    MODE_ENQ_HIGH = 2'd1,
    MODE_DISPATCH = 2'd2,
    MODE_PROMOTE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_HIGH = 2'd1,
    SRC_LOW  = 2'd2
  } source_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_e;

  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] data;
  } ring_ctl_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] fill;
    logic [ID_W-1:0]  rdata;
  } ring_sts_t;

endpackage

>>> hdl/tlrq_in_if.sv
// ----------------------------------------------------------------------------
// tlrq_in_if
// Request channel: mode and process id.
// ----------------------------------------------------------------------------
interface tlrq_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [tlrq_pkg::ID_W-1:0]     proc_id;

  modport source (output valid, output mode, output proc_id, input ready);
  modport sink   (input valid, input mode, input proc_id, output ready);
endinterface

>>> hdl/tlrq_out_if.sv
// ----------------------------------------------------------------------------
// tlrq_out_if
// Result channel: dispatched id, source ring, reject flag and ring counts.
// ----------------------------------------------------------------------------
interface tlrq_out_if;
  logic                          valid;
  logic                          ready;
  logic [tlrq_pkg::ID_W-1:0]     run_id;
  logic [1:0]                    run_source;
  logic                          rejected;
  logic [tlrq_pkg::CNT_W-1:0]    high_count;
  logic [tlrq_pkg::CNT_W-1:0]    low_count;

  modport source (output valid, output run_id, output run_source, output rejected,
                  output high_count, output low_count, input ready);
  modport sink   (input valid, input run_id, input run_source, input rejected,
                  input high_count, input low_count, output ready);
endinterface

>>> hdl/tlrq_ring.sv
// ----------------------------------------------------------------------------
// tlrq_ring
// FIFO ring of process ids in a synchronous memory with a registered read.
// ----------------------------------------------------------------------------
`include "two_level_ready_queue_dispatch_top_assert.svh"

module tlrq_ring #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlrq_pkg::ring_ctl_t ctl_i,
  output tlrq_pkg::ring_sts_t sts_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(DEPTH);

  logic [tlrq_pkg::ID_W-1:0] mem_q [DEPTH];
  logic [tlrq_pkg::ID_W-1:0] rdata_q;
  logic [PTR_W-1:0]          wr_q, wr_d, rd_q, rd_d;
  logic [FILL_W-1:0]         fill_q, fill_d;
  logic                      full, empty, push_ok, pop_ok;

  assign full    = (fill_q == FULL_CNT);
  assign empty   = (fill_q == '0);
  assign push_ok = ctl_i.push && !full;
  assign pop_ok  = ctl_i.pop && !empty;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push_ok) begin
      wr_d = (wr_q == LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_ok) begin
      rd_d = (rd_q == LAST) ? '0 : rd_q + PTR_W'(1);
    end
    case ({push_ok, pop_ok})
      2'b10:   fill_d = fill_q + FILL_W'(1);
      2'b01:   fill_d = fill_q - FILL_W'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  // storage: write on push, read oldest entry on pop
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= ctl_i.data;
    end
    if (pop_ok) begin
      rdata_q <= mem_q[rd_q];
    end
  end

  assign sts_o.full  = full;
  assign sts_o.empty = empty;
  assign sts_o.fill  = tlrq_pkg::CNT_W'(fill_q);
  assign sts_o.rdata = rdata_q;

  `TLRQ_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FULL_CNT)
  `TLRQ_ASSERT_NOW(a_empty_ptrs, empty, wr_q == rd_q)
  `TLRQ_ASSERT_NEXT(a_push_grows, push_ok && !pop_ok, fill_q == $past(fill_q) + FILL_W'(1))

endmodule

>>> hdl/two_level_ready_queue_dispatch_top.sv
// An accepted request moves into the BUSY state, then loads the result register once that register is free.
// No new request is taken in BUSY, while the ring memory read completes.
// A request is taken while the previous result still waits; the result register holds it.
// Reset (rst_ni low, asynchronous): ring pointers and counts clear, registers return to
// process_limit 64 and signal_code 255; ring contents are not cleared.
// ----------------------------------------------------------------------------
// two_level_ready_queue_dispatch_top
// Strict-priority dispatcher over a high and a low ring of process ids.
// ----------------------------------------------------------------------------
`include "two_level_ready_queue_dispatch_top_assert.svh"

module two_level_ready_queue_dispatch_top #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tlrq_in_if.sink                             in_ch,
  tlrq_out_if.source                          out_ch,
  input  logic                                cfg_we_i,
  input  logic [tlrq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tlrq_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  tlrq_pkg::ring_ctl_t lo_ctl, hi_ctl;
  tlrq_pkg::ring_sts_t lo_sts, hi_sts;

  tlrq_pkg::state_e  state_q, state_d;
  tlrq_pkg::source_e src_q, src_d;
  logic              rej_q, rej_d;

  logic [tlrq_pkg::ID_W-1:0] limit_q, sig_q;

  logic                       out_valid_q, out_valid_d;
  logic [tlrq_pkg::ID_W-1:0]  run_q, run_d;
  logic [1:0]                 osrc_q, osrc_d;
  logic                       orej_q, orej_d;
  logic [tlrq_pkg::CNT_W-1:0] hcnt_q, hcnt_d, lcnt_q, lcnt_d;

  logic                       accept, load;
  logic [tlrq_pkg::ID_W-1:0]  pop_id;

  tlrq_ring #(.DEPTH(RING_DEPTH)) u_low (
    .clk_i, .rst_ni, .ctl_i(lo_ctl), .sts_o(lo_sts)
  );

  tlrq_ring #(.DEPTH(RING_DEPTH)) u_high (
    .clk_i, .rst_ni, .ctl_i(hi_ctl), .sts_o(hi_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= tlrq_pkg::PROCESS_LIMIT_RST;
      sig_q   <= tlrq_pkg::SIGNAL_CODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tlrq_pkg::CFG_PROCESS_LIMIT: limit_q <= cfg_data_i;
        tlrq_pkg::CFG_SIGNAL_CODE:   sig_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_q == tlrq_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop_id      = (src_q == tlrq_pkg::SRC_HIGH) ? hi_sts.rdata : lo_sts.rdata;

  always_comb begin
    state_d     = state_q;
    src_d       = src_q;
    rej_d       = rej_q;
    lo_ctl      = '{push: 1'b0, pop: 1'b0, data: in_ch.proc_id};
    hi_ctl      = '{push: 1'b0, pop: 1'b0, data: in_ch.proc_id};
    load        = 1'b0;
    out_valid_d = out_valid_q && !out_ch.ready;
    run_d       = run_q;
    osrc_d      = osrc_q;
    orej_d      = orej_q;
    hcnt_d      = hcnt_q;
    lcnt_d      = lcnt_q;

    unique case (state_q)
      tlrq_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = tlrq_pkg::ST_BUSY;
          src_d   = tlrq_pkg::SRC_NONE;
          rej_d   = 1'b0;
          unique case (tlrq_pkg::mode_e'(in_ch.mode))
            tlrq_pkg::MODE_ENQ_LOW: begin
              lo_ctl.push = 1'b1;
              rej_d       = lo_sts.full;
            end
            tlrq_pkg::MODE_ENQ_HIGH: begin
              hi_ctl.push = 1'b1;
              rej_d       = hi_sts.full;
            end
            tlrq_pkg::MODE_PROMOTE: begin
              lo_ctl.pop  = !lo_sts.empty;
              hi_ctl.push = 1'b1;
              rej_d       = hi_sts.full;
            end
            tlrq_pkg::MODE_DISPATCH: begin
              if (!hi_sts.empty) begin
                hi_ctl.pop = 1'b1;
                src_d      = tlrq_pkg::SRC_HIGH;
              end else if (!lo_sts.empty) begin
                lo_ctl.pop = 1'b1;
                src_d      = tlrq_pkg::SRC_LOW;
              end
            end
            default: ;
          endcase
        end
      end
      tlrq_pkg::ST_BUSY: begin
        // hold until the result register is free
        if (!out_valid_q || out_ch.ready) begin
          load        = 1'b1;
          state_d     = tlrq_pkg::ST_IDLE;
          out_valid_d = 1'b1;
          osrc_d      = src_q;
          orej_d      = rej_q;
          hcnt_d      = hi_sts.fill;
          lcnt_d      = lo_sts.fill;
          run_d       = tlrq_pkg::IDLE_ID;
          if (src_q != tlrq_pkg::SRC_NONE && pop_id != tlrq_pkg::IDLE_ID
              && pop_id < limit_q
              && !(src_q == tlrq_pkg::SRC_HIGH && pop_id == sig_q)) begin
            run_d = pop_id;
          end
        end
      end
      default: state_d = tlrq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlrq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      src_q       <= tlrq_pkg::SRC_NONE;
      rej_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      src_q       <= src_d;
      rej_q       <= rej_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q  <= run_d;
    osrc_q <= osrc_d;
    orej_q <= orej_d;
    hcnt_q <= hcnt_d;
    lcnt_q <= lcnt_d;
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.run_id     = run_q;
  assign out_ch.run_source = osrc_q;
  assign out_ch.rejected   = orej_q;
  assign out_ch.high_count = hcnt_q;
  assign out_ch.low_count  = lcnt_q;

  `TLRQ_ASSERT_NEXT(a_accept_busy, accept, state_q == tlrq_pkg::ST_BUSY)
  `TLRQ_ASSERT_NEXT(a_load_valid, load, out_valid_q && state_q == tlrq_pkg::ST_IDLE)
  `TLRQ_ASSERT_NOW(a_none_idle, out_valid_q && osrc_q == tlrq_pkg::SRC_NONE, run_q == tlrq_pkg::IDLE_ID)

endmodule
